// ----- src/rlec_pkg.sv -----
// ----------------------------------------------------------------------------
// rlec_pkg
// Shared types, operation codes and helpers for the RGB LED effect controller.
// ----------------------------------------------------------------------------
package rlec_pkg;

    localparam int unsigned ColorW   = 8;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned PctW     = 7;
    localparam int unsigned CountW   = 16;
    localparam int unsigned MagW     = ColorW + TimeW + 1;
    localparam int unsigned ProdW    = ColorW + PctW;
    localparam logic [PctW-1:0] PctMax = 7'd100;
    // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
    localparam int unsigned RecipW     = 13;
    localparam logic [RecipW-1:0] Recip100 = 13'd5243;
    localparam int unsigned RecipShift = 19;

    typedef enum logic [3:0] {
        OP_TICK       = 4'd0,
        OP_SET_COLOR  = 4'd1,
        OP_SET_BRIGHT = 4'd2,
        OP_ON         = 4'd3,
        OP_OFF        = 4'd4,
        OP_ON_FOR     = 4'd5,
        OP_FADE_TO    = 4'd6,
        OP_BLINK      = 4'd7,
        OP_STOP_BLINK = 4'd8
    } op_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_BLINK = 7'b0010000,
        ST_SCALE = 7'b0100000,
        ST_DRIVE = 7'b1000000
    } state_t;

    typedef struct packed {
        logic       latch;
        logic       exec;
        logic       mul;
        logic       blend_wr;
        logic [1:0] ch;
        logic       blink;
        logic       scale;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic need_blend;
        logic div_done;
    } sts_t;

    function automatic logic [ColorW-1:0] pct_of(input logic [ProdW-1:0] prod);
        logic [ProdW+RecipW-1:0] wide;
        wide = prod * Recip100;
        return wide[RecipShift +: ColorW];
    endfunction

endpackage

// ----- src/rlec_div.sv -----
// ----------------------------------------------------------------------------
// rlec_div
// Restoring divider, one quotient bit per cycle, for quotients below 256.
// ----------------------------------------------------------------------------
module rlec_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [rlec_pkg::MagW-1:0]   num,
    input  logic [rlec_pkg::TimeW-1:0]  den,
    output logic                        done,
    output logic [rlec_pkg::ColorW-1:0] quo
);
    import rlec_pkg::*;

    logic [TimeW-1:0]  rem_reg, rem_next;
    logic [ColorW-1:0] sh_reg, sh_next;
    logic [3:0]        cnt_reg;
    logic              busy_reg;
    logic [TimeW:0]    trial;
    logic              ge;

    always_comb begin
        trial    = {rem_reg, sh_reg[ColorW-1]};
        ge       = trial >= {1'b0, den};
        rem_next = ge ? TimeW'(trial - {1'b0, den}) : trial[TimeW-1:0];
        sh_next  = {sh_reg[ColorW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'(ColorW);
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 4'd1;
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[MagW-2:ColorW];
            sh_reg  <= num[ColorW-1:0];
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quo  = sh_reg;

endmodule

// ----- src/rlec_dp.sv -----
// ----------------------------------------------------------------------------
// rlec_dp
// Effect state, command execution, fade blend and PWM scaling datapath.
// ----------------------------------------------------------------------------
module rlec_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rlec_pkg::cmd_t              cmd,
    output rlec_pkg::sts_t              sts,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic [3:0]                  s_operation,
    input  logic [31:0]                 s_now_ms,
    input  logic [7:0]                  s_red,
    input  logic [7:0]                  s_green,
    input  logic [7:0]                  s_blue,
    input  logic [7:0]                  s_level_percent,
    input  logic [31:0]                 s_duration_ms,
    input  logic [15:0]                 s_blink_count,
    output logic [7:0]                  m_pwm_red,
    output logic [7:0]                  m_pwm_green,
    output logic [7:0]                  m_pwm_blue,
    output logic                        m_lit,
    output logic                        m_blinking,
    output logic                        m_fading,
    output logic                        m_timed_active
);
    import rlec_pkg::*;

    // latched beat
    logic [3:0]             op_reg;
    logic [TimeW-1:0]       now_reg, dur_reg;
    logic [2:0][ColorW-1:0] rgb_reg;
    logic [ColorW-1:0]      lvl_reg;
    logic [CountW-1:0]      cnt_reg;

    // effect state
    logic                   anode_reg;
    logic [2:0][ColorW-1:0] color_reg, from_reg, to_reg;
    logic [PctW-1:0]        bright_reg;
    logic                   lit_reg, timed_reg, fade_reg, blink_reg, phase_reg;
    logic [TimeW-1:0]       tstart_reg, tlen_reg, fstart_reg, flen_reg;
    logic [TimeW-1:0]       bperiod_reg, blast_reg, elapsed_reg;
    logic [CountW-1:0]      btotal_reg, bdone_reg;
    logic [2:0][ProdW-1:0]  prod_reg;
    logic                   lit_s_reg;

    logic             timed_hit, fade_act, fade_end;
    logic [TimeW-1:0] elapsed;
    logic             is_tick;
    logic             down;
    logic [ColorW-1:0] diff, f_ch, t_ch, q;
    logic [MagW-2:0]  mag;
    logic [MagW-1:0]  num;
    logic             div_done;
    logic             blink_hit;
    logic [CountW-1:0] bdone_inc;

    always_comb begin
        is_tick   = (op_reg == OP_TICK);
        timed_hit = timed_reg && (TimeW'(now_reg - tstart_reg) >= tlen_reg);
        fade_act  = fade_reg && !timed_hit;
        elapsed   = now_reg - fstart_reg;
        fade_end  = elapsed >= flen_reg;
        f_ch      = from_reg[cmd.ch];
        t_ch      = to_reg[cmd.ch];
        down      = t_ch < f_ch;
        diff      = down ? ColorW'(f_ch - t_ch) : ColorW'(t_ch - f_ch);
        mag       = diff * elapsed_reg;
        // round the magnitude up when fading downward
        num       = down ? MagW'({1'b0, mag} + {{(MagW-TimeW){1'b0}}, flen_reg} - MagW'(1))
                         : {1'b0, mag};
        blink_hit = blink_reg && (TimeW'(now_reg - blast_reg) >= bperiod_reg);
        bdone_inc = bdone_reg + CountW'(1);
    end

    rlec_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul),
        .num     (num),
        .den     (flen_reg),
        .done    (div_done),
        .quo     (q)
    );

    assign sts.is_tick    = is_tick;
    assign sts.need_blend = is_tick && fade_act && !fade_end;
    assign sts.div_done   = div_done;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= s_operation;
            now_reg <= s_now_ms;
            rgb_reg <= {s_blue, s_green, s_red};
            lvl_reg <= s_level_percent;
            dur_reg <= s_duration_ms;
            cnt_reg <= s_blink_count;
        end
        if (cmd.exec) begin
            elapsed_reg <= elapsed;
        end
        if (cmd.scale) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= color_reg[i] * bright_reg;
            end
            lit_s_reg <= lit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anode_reg   <= 1'b0;
            color_reg   <= '0;
            from_reg    <= '0;
            to_reg      <= '0;
            bright_reg  <= PctMax;
            lit_reg     <= 1'b0;
            timed_reg   <= 1'b0;
            fade_reg    <= 1'b0;
            blink_reg   <= 1'b0;
            phase_reg   <= 1'b0;
            tstart_reg  <= '0;
            tlen_reg    <= '0;
            fstart_reg  <= '0;
            flen_reg    <= '0;
            bperiod_reg <= '0;
            blast_reg   <= '0;
            btotal_reg  <= '0;
            bdone_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                anode_reg <= cfg_wr_data;
            end
            if (cmd.exec) begin
                case (op_reg)
                    OP_TICK: begin
                        if (timed_hit) begin
                            lit_reg   <= 1'b0;
                            timed_reg <= 1'b0;
                            fade_reg  <= 1'b0;
                        end
                        if (fade_act) begin
                            blink_reg  <= 1'b0;
                            bdone_reg  <= '0;
                            btotal_reg <= '0;
                            if (fade_end) begin
                                color_reg <= to_reg;
                                fade_reg  <= 1'b0;
                            end
                        end
                    end
                    OP_SET_COLOR: begin
                        blink_reg  <= 1'b0;
                        bdone_reg  <= '0;
                        btotal_reg <= '0;
                        color_reg  <= rgb_reg;
                    end
                    OP_SET_BRIGHT: begin
                        bright_reg <= (lvl_reg > ColorW'(PctMax)) ? PctMax : lvl_reg[PctW-1:0];
                    end
                    OP_ON: begin
                        blink_reg  <= 1'b0;
                        bdone_reg  <= '0;
                        btotal_reg <= '0;
                        lit_reg    <= 1'b1;
                    end
                    OP_OFF: begin
                        lit_reg   <= 1'b0;
                        timed_reg <= 1'b0;
                        fade_reg  <= 1'b0;
                    end
                    OP_ON_FOR: begin
                        blink_reg  <= 1'b0;
                        bdone_reg  <= '0;
                        btotal_reg <= '0;
                        timed_reg  <= 1'b1;
                        tstart_reg <= now_reg;
                        tlen_reg   <= dur_reg;
                        lit_reg    <= 1'b1;
                    end
                    OP_FADE_TO: begin
                        blink_reg  <= 1'b0;
                        bdone_reg  <= '0;
                        btotal_reg <= '0;
                        fade_reg   <= 1'b1;
                        from_reg   <= color_reg;
                        to_reg     <= rgb_reg;
                        fstart_reg <= now_reg;
                        flen_reg   <= dur_reg;
                        lit_reg    <= 1'b1;
                    end
                    OP_BLINK: begin
                        blink_reg   <= 1'b1;
                        bperiod_reg <= dur_reg;
                        btotal_reg  <= cnt_reg;
                        bdone_reg   <= '0;
                        phase_reg   <= 1'b0;
                        blast_reg   <= now_reg;
                        lit_reg     <= 1'b0;
                    end
                    OP_STOP_BLINK: begin
                        blink_reg  <= 1'b0;
                        bdone_reg  <= '0;
                        btotal_reg <= '0;
                        lit_reg    <= 1'b0;
                        timed_reg  <= 1'b0;
                        fade_reg   <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.blend_wr) begin
                color_reg[cmd.ch] <= down ? ColorW'(f_ch - q) : ColorW'(f_ch + q);
            end
            if (cmd.blink && blink_hit) begin
                blast_reg <= now_reg;
                if (phase_reg) begin
                    lit_reg   <= 1'b0;
                    phase_reg <= 1'b0;
                    bdone_reg <= bdone_inc;
                    if (btotal_reg != '0 && bdone_inc >= btotal_reg) begin
                        blink_reg <= 1'b0;
                    end
                end else begin
                    lit_reg   <= 1'b1;
                    phase_reg <= 1'b1;
                end
            end
        end
    end

    function automatic logic [ColorW-1:0] duty(input logic [ProdW-1:0] p, input logic on,
                                               input logic inv);
        logic [ColorW-1:0] d;
        d = on ? pct_of(p) : '0;
        return inv ? ~d : d;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_pwm_red      <= duty(prod_reg[0], lit_s_reg, anode_reg);
            m_pwm_green    <= duty(prod_reg[1], lit_s_reg, anode_reg);
            m_pwm_blue     <= duty(prod_reg[2], lit_s_reg, anode_reg);
            m_lit          <= lit_reg;
            m_blinking     <= blink_reg;
            m_fading       <= fade_reg;
            m_timed_active <= timed_reg;
        end
    end

endmodule

// ----- src/rlec_ctrl.sv -----
// ----------------------------------------------------------------------------
// rlec_ctrl
// Sequencer: command, per-channel fade blend, blink toggle, scale and output.
// ----------------------------------------------------------------------------
module rlec_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output rlec_pkg::cmd_t cmd,
    input  rlec_pkg::sts_t sts
);
    import rlec_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic       mvalid_reg, mvalid_next;
    logic       can_load;

    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        cmd         = '0;
        cmd.ch      = ch_reg;
        can_load    = !mvalid_reg || m_ready;
        mvalid_next = mvalid_reg && !m_ready;
        s_ready     = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                ch_next  = 2'd0;
                if (sts.need_blend) begin
                    state_next = ST_MUL;
                end else if (sts.is_tick) begin
                    state_next = ST_BLINK;
                end else begin
                    state_next = ST_SCALE;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.blend_wr = 1'b1;
                    if (ch_reg == 2'd2) begin
                        state_next = ST_BLINK;
                    end else begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_BLINK: begin
                cmd.blink  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DRIVE;
            end
            ST_DRIVE: begin
                // hold until the output register is free
                if (can_load) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ch_reg     <= 2'd0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;

endmodule

// ----- src/rgb_led_effect_controller_top.sv -----
// ----------------------------------------------------------------------------
// rgb_led_effect_controller_top
// RGB LED effect controller: colour, brightness, timed on, fade and blink.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  s_       | s_valid / s_ready  | operation, now_ms, rgb, level, duration, count
//  m_       | m_valid / m_ready  | pwm rgb, lit, blinking, fading, timed_active
//  cfg_     | cfg_wr_en          | cfg_wr_data = anode mode
//
//  A command passes through the execute, scale and drive states before its result
//  beat; a plain tick adds a blink state, and a tick that steps a fade runs, per
//  channel, an operand load, the 8-bit restoring divide and a blend write before
//  the blink state. s_ready returns the cycle after the result loads.
//  Synchronous active-low reset; no clearing pass.
//  A result waiting in the output register does not block the next beat;
//  only the final load waits on m_ready.
// ----------------------------------------------------------------------------
module rgb_led_effect_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_operation,
    input  logic [31:0] s_now_ms,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_level_percent,
    input  logic [31:0] s_duration_ms,
    input  logic [15:0] s_blink_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pwm_red,
    output logic [7:0]  m_pwm_green,
    output logic [7:0]  m_pwm_blue,
    output logic        m_lit,
    output logic        m_blinking,
    output logic        m_fading,
    output logic        m_timed_active
);
    import rlec_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rlec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    rlec_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_operation     (s_operation),
        .s_now_ms        (s_now_ms),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .s_level_percent (s_level_percent),
        .s_duration_ms   (s_duration_ms),
        .s_blink_count   (s_blink_count),
        .m_pwm_red       (m_pwm_red),
        .m_pwm_green     (m_pwm_green),
        .m_pwm_blue      (m_pwm_blue),
        .m_lit           (m_lit),
        .m_blinking      (m_blinking),
        .m_fading        (m_fading),
        .m_timed_active  (m_timed_active)
    );

endmodule
